// ===== hdl/rcwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray-cast wall column texel package
// Shared constants, beat types and the cosine table generator for the
// per-row wall, ceiling and floor decision pipeline.
// ----------------------------------------------------------------------------
package rcwt_pkg;

  // Fixed-point setup.
  localparam int FRAC_BITS       = 16;
  localparam int COS_TABLE_DEPTH = 1024;

  // Angle that maps to the last table entry, in Q2.14 radians.
  localparam int QuarterTurn = 25736;

  // Field widths.
  localparam int HitW    = 22;
  localparam int LenW    = 22;
  localparam int AngW    = 16;
  localparam int RowW    = 11;
  localparam int HeightW = 12;
  localparam int ColorW  = 24;
  localparam int TexRegW = 9;
  localparam int TexelW  = 8;
  localparam int CosW    = 16;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCeilingColor  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFloorColor    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTextureWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTextureHeight = 3'd4;

  // Cosine index: idx = |angle| * depth / QuarterTurn by reciprocal.
  localparam int IdxW       = $clog2(COS_TABLE_DEPTH);
  localparam int AngMagW    = AngW;
  localparam int CosXW      = AngMagW + IdxW;
  localparam int RecipShift = CosXW + 14;
  localparam int CosQW      = CosXW - 14;
  localparam longint unsigned CosRecip = (64'd1 << RecipShift) / QuarterTurn;

  // Wall height division: WQ = (H << (FRAC_BITS + 31)) / (len * cos).
  localparam int DenW      = LenW + CosW;
  localparam int NumShift  = FRAC_BITS - 1;
  localparam int RemW      = ((HeightW + NumShift) > DenW ? (HeightW + NumShift) : DenW) + 1;
  localparam int WqW       = 32;
  localparam int WqStages  = WqW / 2;

  // Row classification and texel row division.
  localparam int RowShift   = 17;
  localparam int SumW       = WqW + 2;
  localparam int ProdW      = SumW + TexRegW;
  localparam int TremW      = WqW + 2;
  localparam int TrowStages = TexelW / 2;

  // Face test.
  localparam int UW        = FRAC_BITS + 1;
  localparam int FracOne   = 1 << FRAC_BITS;
  localparam int EpsRound  = (FracOne + 50000) / 100000;
  localparam int Eps       = (EpsRound == 0) ? 1 : EpsRound;
  localparam int TexProdW  = UW + TexRegW;

  typedef enum logic [1:0] {
    RegionCeiling = 2'd0,
    RegionWall    = 2'd1,
    RegionFloor   = 2'd2
  } region_e;

  typedef enum logic [1:0] {
    FaceEast  = 2'd0,
    FaceWest  = 2'd1,
    FaceSouth = 2'd2,
    FaceNorth = 2'd3
  } face_e;

  // Input fields that travel along the pipeline.
  typedef struct packed {
    logic [HitW-1:0] hit_x;
    logic [HitW-1:0] hit_y;
    logic [LenW-1:0] ray_length;
    logic [RowW-1:0] row;
  } item_t;

  // Live configuration, texture sizes already clamped to 1..256.
  typedef struct packed {
    logic [HeightW-1:0] height;
    logic [ColorW-1:0]  ceiling;
    logic [ColorW-1:0]  floor_c;
    logic [TexRegW-1:0] tw;
    logic [TexRegW-1:0] th;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    item_t           item;
    logic [CosW-1:0] cosine;
  } cos_beat_t;

  typedef struct packed {
    logic           valid;
    item_t          item;
    logic [WqW-1:0] wq;
  } ht_beat_t;

  typedef struct packed {
    region_e           region;
    face_e             face;
    logic [TexelW-1:0] texel_col;
    logic [TexelW-1:0] texel_row;
    logic [ColorW-1:0] fill;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_beat_t;

  // Per-row data carried alongside the texel row division.
  typedef struct packed {
    region_e           region;
    face_e             face;
    logic [TexelW-1:0] texel_col;
    logic [ColorW-1:0] fill;
    logic              cap;
  } shade_meta_t;

  typedef logic [CosW-1:0] cos_rom_t [COS_TABLE_DEPTH];

  // One table entry: integer Taylor series in Q28, rounded to Q1.15.
  function automatic logic [CosW-1:0] cos_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    x    = ((64'(k) * 64'(QuarterTurn)) << 14) / 64'(COS_TABLE_DEPTH);
    x2   = (x * x) >> 28;
    term = 64'd1 << 28;
    sum  = longint'(term);
    for (int n = 0; n < 8; n++) begin
      term = ((term * x2) >> 28) / 64'((2 * n + 1) * (2 * n + 2));
      if ((n % 2) == 1) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) + 64'd4096) >> 13;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[CosW-1:0];
  endfunction

  // Whole table, evaluated at elaboration.
  function automatic cos_rom_t gen_cos_rom();
    cos_rom_t r;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      r[k] = cos_entry(k);
    end
    return r;
  endfunction

endpackage

// ===== hdl/rcwt_cos_lookup.sv =====
// ----------------------------------------------------------------------------
// Cosine lookup
// Turns the signed angle offset into a table index by reciprocal
// multiplication and reads the cosine ROM. Three register stages.
// ----------------------------------------------------------------------------
module rcwt_cos_lookup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  rcwt_pkg::item_t                     item_i,
  input  logic signed [rcwt_pkg::AngW-1:0]    angle_i,
  output rcwt_pkg::cos_beat_t                 beat_o
);
  import rcwt_pkg::*;

  localparam cos_rom_t CosRom = gen_cos_rom();
  localparam logic [CosXW-1:0] Recip = CosRecip[CosXW-1:0];

  logic [AngMagW-1:0]   mag;
  logic [CosXW-1:0]     x_full;
  logic [2*CosXW-1:0]   recip_prod;
  logic [CosXW-1:0]     q0_times;
  logic [CosXW-1:0]     idx_rem;
  logic [CosQW-1:0]     q_fix;
  logic [IdxW-1:0]      idx_d;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q;
  item_t                s1_item_q, s2_item_q, s3_item_q;
  logic [CosXW-1:0]     s1_x_q;
  logic [CosQW-1:0]     s1_q0_q;
  logic [IdxW-1:0]      s2_idx_q;
  logic [CosW-1:0]      s3_cos_q;

  // Stage 1: magnitude of the angle and a first quotient estimate.
  always_comb begin
    mag        = angle_i[AngW-1] ? (~angle_i + 1'b1) : angle_i;
    x_full     = CosXW'(mag) * CosXW'(COS_TABLE_DEPTH);
    recip_prod = (2*CosXW)'(x_full) * (2*CosXW)'(Recip);
  end

  // Stage 2: the estimate is low by at most one; correct it and cap.
  always_comb begin
    q0_times = CosXW'(s1_q0_q) * CosXW'(QuarterTurn);
    idx_rem  = s1_x_q - q0_times;
    q_fix    = (idx_rem >= CosXW'(QuarterTurn)) ? (s1_q0_q + 1'b1) : s1_q0_q;
    idx_d    = (q_fix > CosQW'(COS_TABLE_DEPTH - 1)) ? IdxW'(COS_TABLE_DEPTH - 1)
                                                      : q_fix[IdxW-1:0];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Payload stages; stage 3 is the registered ROM read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_item_q <= item_i;
      s1_x_q    <= x_full;
      s1_q0_q   <= recip_prod[2*CosXW-1:RecipShift];
      s2_item_q <= s1_item_q;
      s2_idx_q  <= idx_d;
      s3_item_q <= s2_item_q;
      s3_cos_q  <= CosRom[s2_idx_q];
    end
  end

  assign beat_o.valid  = s3_vld_q;
  assign beat_o.item   = s3_item_q;
  assign beat_o.cosine = s3_cos_q;

endmodule

// ===== hdl/rcwt_height_div.sv =====
// ----------------------------------------------------------------------------
// Wall height divider
// Forms the denominator ray_length * cosine and divides the scaled screen
// height by it, two quotient bits per stage, saturating to all ones.
// ----------------------------------------------------------------------------
module rcwt_height_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  rcwt_pkg::cos_beat_t             beat_i,
  input  logic [rcwt_pkg::HeightW-1:0]    height_i,
  output rcwt_pkg::ht_beat_t              beat_o
);
  import rcwt_pkg::*;

  logic                  p0_vld_q;
  item_t                 p0_item_q;
  logic [DenW-1:0]       p0_den_q;

  logic [WqStages:0]     vld_q;
  logic [WqStages:0]     sat_q;
  item_t                 item_q [WqStages+1];
  logic [DenW-1:0]       den_q  [WqStages+1];
  logic [RemW-1:0]       rem_q  [WqStages+1];
  logic [WqW-1:0]        quo_q  [WqStages+1];

  logic [RemW-1:0]       rem_d  [WqStages];
  logic [WqW-1:0]        quo_d  [WqStages];
  logic [RemW-1:0]       num0;
  logic [RemW-1:0]       shifted;

  // Numerator high part; the low part of the dividend is all zeros.
  assign num0 = RemW'(height_i) << NumShift;

  // Two restoring division steps per stage.
  always_comb begin
    shifted = '0;
    for (int s = 0; s < WqStages; s++) begin
      rem_d[s] = rem_q[s];
      quo_d[s] = quo_q[s];
      for (int j = 0; j < 2; j++) begin
        shifted = {rem_d[s][RemW-2:0], 1'b0};
        if (shifted >= RemW'(den_q[s])) begin
          rem_d[s] = shifted - RemW'(den_q[s]);
          quo_d[s] = {quo_d[s][WqW-2:0], 1'b1};
        end else begin
          rem_d[s] = shifted;
          quo_d[s] = {quo_d[s][WqW-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      vld_q    <= '0;
    end else if (en_i) begin
      p0_vld_q <= beat_i.valid;
      vld_q    <= {vld_q[WqStages-1:0], p0_vld_q};
    end
  end

  // Denominator product, divider setup and the division stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_item_q <= beat_i.item;
      p0_den_q  <= DenW'(beat_i.item.ray_length) * DenW'(beat_i.cosine);
      item_q[0] <= p0_item_q;
      den_q[0]  <= p0_den_q;
      rem_q[0]  <= num0;
      quo_q[0]  <= '0;
      sat_q[0]  <= (num0 >= RemW'(p0_den_q));
      for (int s = 0; s < WqStages; s++) begin
        item_q[s+1] <= item_q[s];
        den_q[s+1]  <= den_q[s];
        rem_q[s+1]  <= rem_d[s];
        quo_q[s+1]  <= quo_d[s];
        sat_q[s+1]  <= sat_q[s];
      end
    end
  end

  assign beat_o.valid = vld_q[WqStages];
  assign beat_o.item  = item_q[WqStages];
  assign beat_o.wq    = sat_q[WqStages] ? '1 : quo_q[WqStages];

endmodule

// ===== hdl/rcwt_shade.sv =====
// ----------------------------------------------------------------------------
// Row shading
// Classifies the row as ceiling, wall or floor, picks the wall face and
// texel column, and divides out the texel row two bits per stage.
// ----------------------------------------------------------------------------
module rcwt_shade (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  rcwt_pkg::ht_beat_t    beat_i,
  input  rcwt_pkg::cfg_t        cfg_i,
  output rcwt_pkg::res_beat_t   beat_o
);
  import rcwt_pkg::*;

  logic [SumW-1:0]       r17, h17, wqx, num_c;
  logic                  ceil_c, wall_c;
  logic [FRAC_BITS-1:0]  fx, fy;
  face_e                 face_c;
  logic [UW-1:0]         u_c;
  region_e               region_c;
  logic [ColorW-1:0]     fill_c;

  logic                  c1_vld_q;
  region_e               c1_region_q;
  face_e                 c1_face_q;
  logic [UW-1:0]         c1_u_q;
  logic [SumW-1:0]       c1_num_q;
  logic                  c1_cap_q;
  logic [ColorW-1:0]     c1_fill_q;
  logic [WqW-1:0]        c1_wq_q;

  logic [ProdW-1:0]      row_prod;
  logic [TexProdW-1:0]   col_prod;
  logic [TexRegW:0]      col_full;
  logic [TexRegW-1:0]    tw_m1, th_m1;
  logic [TexelW-1:0]     col_c;
  shade_meta_t           meta_c;

  logic [TrowStages:0]   vld_q;
  shade_meta_t           meta_q [TrowStages+1];
  logic [TremW-1:0]      dv_q   [TrowStages+1];
  logic [TremW-1:0]      rem_q  [TrowStages+1];
  logic [TexelW-1:0]     lo_q   [TrowStages+1];
  logic [TexelW-1:0]     quo_q  [TrowStages+1];

  logic [TremW-1:0]      rem_d  [TrowStages];
  logic [TexelW-1:0]     lo_d   [TrowStages];
  logic [TexelW-1:0]     quo_d  [TrowStages];
  logic [TremW-1:0]      shifted;

  // Stage 1: region compares and face selection.
  always_comb begin
    r17    = SumW'(beat_i.item.row) << RowShift;
    h17    = SumW'(cfg_i.height >> 1) << RowShift;
    wqx    = SumW'(beat_i.wq);
    num_c  = r17 + wqx - h17;
    ceil_c = (r17 + wqx) <= h17;
    wall_c = !ceil_c && (HeightW'(beat_i.item.row) <= cfg_i.height) && (r17 <= (h17 + wqx));
    fx     = beat_i.item.hit_x[FRAC_BITS-1:0];
    fy     = beat_i.item.hit_y[FRAC_BITS-1:0];
    if ((beat_i.item.hit_x >= HitW'(Eps)) && (UW'(fx) < UW'(Eps))) begin
      face_c = FaceEast;
      u_c    = UW'(fy);
    end else if ((UW'(fx) + UW'(Eps)) >= UW'(FracOne)) begin
      face_c = FaceWest;
      u_c    = UW'(FracOne) - UW'(fy);
    end else if ((beat_i.item.hit_y >= HitW'(Eps)) && (UW'(fy) < UW'(Eps))) begin
      face_c = FaceSouth;
      u_c    = UW'(FracOne) - UW'(fx);
    end else begin
      face_c = FaceNorth;
      u_c    = UW'(fx);
    end
    if (ceil_c) begin
      region_c = RegionCeiling;
      fill_c   = cfg_i.ceiling;
    end else if (wall_c) begin
      region_c = RegionWall;
      fill_c   = '0;
    end else begin
      region_c = RegionFloor;
      fill_c   = cfg_i.floor_c;
    end
  end

  // Stage 2: texel products and the column cap.
  always_comb begin
    tw_m1    = cfg_i.tw - 1'b1;
    th_m1    = cfg_i.th - 1'b1;
    row_prod = ProdW'(c1_num_q) * ProdW'(cfg_i.th);
    col_prod = TexProdW'(c1_u_q) * TexProdW'(cfg_i.tw);
    col_full = col_prod[FRAC_BITS +: TexRegW+1];
    col_c    = (col_full > (TexRegW+1)'(tw_m1)) ? tw_m1[TexelW-1:0] : col_full[TexelW-1:0];
    meta_c.region    = c1_region_q;
    meta_c.face      = (c1_region_q == RegionWall) ? c1_face_q : FaceEast;
    meta_c.texel_col = (c1_region_q == RegionWall) ? col_c : '0;
    meta_c.fill      = c1_fill_q;
    meta_c.cap       = c1_cap_q;
  end

  // Texel row division, two bits per stage, dividend bits shifted in.
  always_comb begin
    shifted = '0;
    for (int s = 0; s < TrowStages; s++) begin
      rem_d[s] = rem_q[s];
      lo_d[s]  = lo_q[s];
      quo_d[s] = quo_q[s];
      for (int j = 0; j < 2; j++) begin
        shifted  = {rem_d[s][TremW-2:0], lo_d[s][TexelW-1]};
        lo_d[s]  = {lo_d[s][TexelW-2:0], 1'b0};
        if (shifted >= dv_q[s]) begin
          rem_d[s] = shifted - dv_q[s];
          quo_d[s] = {quo_d[s][TexelW-2:0], 1'b1};
        end else begin
          rem_d[s] = shifted;
          quo_d[s] = {quo_d[s][TexelW-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
      vld_q    <= '0;
    end else if (en_i) begin
      c1_vld_q <= beat_i.valid;
      vld_q    <= {vld_q[TrowStages-1:0], c1_vld_q};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_region_q <= region_c;
      c1_face_q   <= face_c;
      c1_u_q      <= u_c;
      c1_num_q    <= num_c;
      c1_cap_q    <= num_c >= {wqx[SumW-2:0], 1'b0};
      c1_fill_q   <= fill_c;
      c1_wq_q     <= beat_i.wq;
      meta_q[0]   <= meta_c;
      dv_q[0]     <= TremW'({c1_wq_q, 1'b0});
      rem_q[0]    <= row_prod[TexelW +: TremW];
      lo_q[0]     <= row_prod[TexelW-1:0];
      quo_q[0]    <= '0;
      for (int s = 0; s < TrowStages; s++) begin
        meta_q[s+1] <= meta_q[s];
        dv_q[s+1]   <= dv_q[s];
        rem_q[s+1]  <= rem_d[s];
        lo_q[s+1]   <= lo_d[s];
        quo_q[s+1]  <= quo_d[s];
      end
    end
  end

  // Result assembly; a row at or past the texture's bottom edge is capped.
  always_comb begin
    beat_o.valid          = vld_q[TrowStages];
    beat_o.res.region     = meta_q[TrowStages].region;
    beat_o.res.face       = meta_q[TrowStages].face;
    beat_o.res.texel_col  = meta_q[TrowStages].texel_col;
    beat_o.res.fill       = meta_q[TrowStages].fill;
    if (meta_q[TrowStages].region != RegionWall) begin
      beat_o.res.texel_row = '0;
    end else if (meta_q[TrowStages].cap) begin
      beat_o.res.texel_row = th_m1[TexelW-1:0];
    end else begin
      beat_o.res.texel_row = quo_q[TrowStages];
    end
  end

endmodule

// ===== hdl/raycast_wall_column_texel_top.sv =====
// ----------------------------------------------------------------------------
// Ray-cast wall column texel, top level
// Per pixel row of a ray-cast column: wall height with fish-eye correction,
// ceiling, wall or floor class, wall face, texel column and texel row.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while in_stall_o is low and returns one
// result beat for each, in order. Beats pass through the cosine lookup, the
// 32-bit wall height divider, which resolves two quotient bits per pipeline
// stage, and the texel row divider. All stages advance together; a two-beat
// output queue sits behind them, so input keeps flowing while one result
// waits, and in_stall_o rises only when both queue slots hold results.
// Configuration writes are always ready and take effect at once; write them
// only while the block is empty.
module raycast_wall_column_texel_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input beats.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rcwt_pkg::HitW-1:0]            hit_x_i,
  input  logic [rcwt_pkg::HitW-1:0]            hit_y_i,
  input  logic [rcwt_pkg::LenW-1:0]            ray_length_i,
  input  logic signed [rcwt_pkg::AngW-1:0]     angle_offset_i,
  input  logic [rcwt_pkg::RowW-1:0]            row_i,
  // Result beats.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           region_o,
  output logic [1:0]                           face_o,
  output logic [rcwt_pkg::TexelW-1:0]          texel_col_o,
  output logic [rcwt_pkg::TexelW-1:0]          texel_row_o,
  output logic [rcwt_pkg::ColorW-1:0]          fill_color_o,
  // Configuration writes.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rcwt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rcwt_pkg::ColorW-1:0]          cfg_data_i
);
  import rcwt_pkg::*;

  logic [HeightW-1:0]  height_q;
  logic [ColorW-1:0]   ceiling_q, floor_q;
  logic [TexRegW-1:0]  tex_w_q, tex_h_q;
  cfg_t                cfg;

  logic                en;
  item_t               item_in;
  cos_beat_t           cos_beat;
  ht_beat_t            ht_beat;
  res_beat_t           res_beat;

  logic [1:0]          count_q;
  result_t             slot0_q, slot1_q;
  logic                push, pop;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q  <= HeightW'(480);
      ceiling_q <= '0;
      floor_q   <= '0;
      tex_w_q   <= TexRegW'(64);
      tex_h_q   <= TexRegW'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgScreenHeight:  height_q  <= cfg_data_i[HeightW-1:0];
        CfgCeilingColor:  ceiling_q <= cfg_data_i;
        CfgFloorColor:    floor_q   <= cfg_data_i;
        CfgTextureWidth:  tex_w_q   <= cfg_data_i[TexRegW-1:0];
        CfgTextureHeight: tex_h_q   <= cfg_data_i[TexRegW-1:0];
        default: ;
      endcase
    end
  end

  // Texture sizes of zero act as one, sizes above 256 act as 256.
  always_comb begin
    cfg.height  = height_q;
    cfg.ceiling = ceiling_q;
    cfg.floor_c = floor_q;
    cfg.tw      = (tex_w_q == '0) ? TexRegW'(1)
                : (tex_w_q > TexRegW'(256)) ? TexRegW'(256) : tex_w_q;
    cfg.th      = (tex_h_q == '0) ? TexRegW'(1)
                : (tex_h_q > TexRegW'(256)) ? TexRegW'(256) : tex_h_q;
  end

  // The pipeline moves whenever the output queue has a free slot.
  assign en         = (count_q != 2'd2);
  assign in_stall_o = !en;

  assign item_in.hit_x      = hit_x_i;
  assign item_in.hit_y      = hit_y_i;
  assign item_in.ray_length = ray_length_i;
  assign item_in.row        = row_i;

  rcwt_cos_lookup u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (item_in),
    .angle_i (angle_offset_i),
    .beat_o  (cos_beat)
  );

  rcwt_height_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .beat_i   (cos_beat),
    .height_i (height_q),
    .beat_o   (ht_beat)
  );

  rcwt_shade u_shade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .beat_i (ht_beat),
    .cfg_i  (cfg),
    .beat_o (res_beat)
  );

  // Two-slot output queue; slot 0 is the head.
  assign push = res_beat.valid && en;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (push && !pop) begin
      count_q <= count_q + 2'd1;
    end else if (pop && !push) begin
      count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && pop) begin
      if (count_q == 2'd2) begin
        slot0_q <= slot1_q;
        slot1_q <= res_beat.res;
      end else begin
        slot0_q <= res_beat.res;
      end
    end else if (pop) begin
      slot0_q <= slot1_q;
    end else if (push) begin
      if (count_q == 2'd0) begin
        slot0_q <= res_beat.res;
      end else begin
        slot1_q <= res_beat.res;
      end
    end
  end

  assign out_valid_o  = (count_q != 2'd0);
  assign region_o     = slot0_q.region;
  assign face_o       = slot0_q.face;
  assign texel_col_o  = slot0_q.texel_col;
  assign texel_row_o  = slot0_q.texel_row;
  assign fill_color_o = slot0_q.fill;

  // The queue never holds more than two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("output queue overflow");

  // Wall rows carry no fill color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (region_o == RegionWall)) |-> (fill_color_o == '0))
    else $error("wall row with fill color");

  // Ceiling and floor rows carry no face or texel coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (region_o != RegionWall)) |->
      (face_o == 2'd0 && texel_col_o == '0 && texel_row_o == '0))
    else $error("texel data on a non-wall row");

endmodule

// ===== test/rcwt_checker.sv =====
// ----------------------------------------------------------------------------
// Ray-cast wall column texel checker
// Watches the input, result and configuration channels of the block. It keeps
// its own copy of the registers and the cosine table, predicts each result
// beat and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module rcwt_checker
  import rcwt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [HitW-1:0]     hit_x_i,
  input  logic [HitW-1:0]     hit_y_i,
  input  logic [LenW-1:0]     ray_length_i,
  input  logic [AngW-1:0]     angle_offset_i,
  input  logic [RowW-1:0]     row_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [1:0]          region_i,
  input  logic [1:0]          face_i,
  input  logic [TexelW-1:0]   texel_col_i,
  input  logic [TexelW-1:0]   texel_row_i,
  input  logic [ColorW-1:0]   fill_color_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [ColorW-1:0]   cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    region_e           region;
    face_e             face;
    logic [TexelW-1:0] tcol;
    logic [TexelW-1:0] trow;
    logic [ColorW-1:0] fill;
  } shade_t;

  logic [CosW-1:0]    cos_table [COS_TABLE_DEPTH];
  logic [HeightW-1:0] scr_h;
  logic [ColorW-1:0]  ceil_rgb;
  logic [ColorW-1:0]  floor_rgb;
  logic [TexRegW-1:0] tex_w;
  logic [TexRegW-1:0] tex_h;
  shade_t             shades_due [$];
  int                 fails;

  // Cosine of k/depth of a quarter turn: Taylor series in Q28, rounded to Q1.15.
  function automatic logic [CosW-1:0] taylor_cos(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          acc;
    x = ((k * 25736) << 14) / COS_TABLE_DEPTH;
    x2 = (x * x) >> 28;
    term = 64'd1 << 28;
    acc = 64'sd1 << 28;
    for (int n = 0; n < 8; n++) begin
      term = ((term * x2) >> 28) / ((2 * n + 1) * (2 * n + 2));
      if (n % 2 == 1) acc = acc + longint'(term);
      else acc = acc - longint'(term);
    end
    if (acc < 0) acc = 0;
    v = (longint'(acc) + 4096) >> 13;
    if (v > 32768) v = 32768;
    return v[CosW-1:0];
  endfunction

  function automatic longint unsigned tex_size(input logic [TexRegW-1:0] s);
    if (s == 0) return 1;
    if (s > 256) return 256;
    return 64'(s);
  endfunction

  // Shading of one pixel row under the current registers.
  function automatic shade_t shade_row(input logic [HitW-1:0] hx, input logic [HitW-1:0] hy,
                                       input logic [LenW-1:0] len, input logic [AngW-1:0] ang,
                                       input logic [RowW-1:0] row);
    shade_t s;
    longint unsigned one, mag, idx, den, wq, half, r17, h17, eps, fx, fy, u, tw, th, num;
    longint unsigned tc, tr;
    one = 64'd1 << FRAC_BITS;
    s.region = RegionCeiling;
    s.face = FaceEast;
    s.tcol = '0;
    s.trow = '0;
    s.fill = '0;
    mag = ang[AngW-1] ? (64'h10000 - ang) : ang;
    idx = (mag * COS_TABLE_DEPTH) / 25736;
    if (idx > COS_TABLE_DEPTH - 1) idx = COS_TABLE_DEPTH - 1;
    den = len * cos_table[idx[IdxW-1:0]];
    if (den == 0) wq = 64'hFFFF_FFFF;
    else begin
      wq = (longint'(scr_h) << (FRAC_BITS + 31)) / den;
      if (wq > 64'hFFFF_FFFF) wq = 64'hFFFF_FFFF;
    end
    half = scr_h >> 1;
    r17 = longint'(row) << 17;
    h17 = half << 17;
    if (r17 + wq <= h17) begin
      s.fill = ceil_rgb;
    end else if (row <= scr_h && r17 <= h17 + wq) begin
      tw = tex_size(tex_w);
      th = tex_size(tex_h);
      s.region = RegionWall;
      eps = (one + 50000) / 100000;
      if (eps == 0) eps = 1;
      fx = hx & (one - 1);
      fy = hy & (one - 1);
      if (hx >= eps && fx < eps) begin
        s.face = FaceEast;
        u = fy;
      end else if (fx + eps >= one) begin
        s.face = FaceWest;
        u = one - fy;
      end else if (hy >= eps && fy < eps) begin
        s.face = FaceSouth;
        u = one - fx;
      end else begin
        s.face = FaceNorth;
        u = fx;
      end
      tc = (u * tw) >> FRAC_BITS;
      if (tc > tw - 1) tc = tw - 1;
      num = r17 + wq - h17;
      tr = (wq == 0) ? 0 : (num * th) / (wq * 2);
      if (tr > th - 1) tr = th - 1;
      s.tcol = tc[TexelW-1:0];
      s.trow = tr[TexelW-1:0];
    end else begin
      s.region = RegionFloor;
      s.fill = floor_rgb;
    end
    return s;
  endfunction

  initial begin
    for (int k = 0; k < COS_TABLE_DEPTH; k++) cos_table[k] = taylor_cos(k);
  end

  assign fail_count_o = fails;
  assign pending_o = shades_due.size();

  // Register copy, prediction on accepted input beats, comparison on result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    shade_t e;
    if (!rst_ni) begin
      scr_h = HeightW'(480);
      ceil_rgb = '0;
      floor_rgb = '0;
      tex_w = TexRegW'(64);
      tex_h = TexRegW'(64);
      shades_due.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgScreenHeight:  scr_h = cfg_data_i[HeightW-1:0];
          CfgCeilingColor:  ceil_rgb = cfg_data_i;
          CfgFloorColor:    floor_rgb = cfg_data_i;
          CfgTextureWidth:  tex_w = cfg_data_i[TexRegW-1:0];
          CfgTextureHeight: tex_h = cfg_data_i[TexRegW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (shades_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: result beat with no expectation", $realtime);
        end else begin
          e = shades_due.pop_front();
          if (region_i !== e.region || face_i !== e.face || texel_col_i !== e.tcol ||
              texel_row_i !== e.trow || fill_color_i !== e.fill) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: mismatch exp reg %0d face %0d col %0d row %0d fill %h, ",
                        "got %0d %0d %0d %0d %h"},
                       $realtime, e.region, e.face, e.tcol, e.trow, e.fill,
                       region_i, face_i, texel_col_i, texel_row_i, fill_color_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        shades_due.push_back(shade_row(hit_x_i, hit_y_i, ray_length_i, angle_offset_i, row_i));
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Ray-cast wall column texel testbench
// Drives pixel-row beats through several register settings with random idle
// and stall bursts; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import rcwt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [HitW-1:0]     hit_x_i = '0;
  logic [HitW-1:0]     hit_y_i = '0;
  logic [LenW-1:0]     ray_length_i = '0;
  logic [AngW-1:0]     angle_offset_i = '0;
  logic [RowW-1:0]     row_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          region_o;
  logic [1:0]          face_o;
  logic [TexelW-1:0]   texel_col_o;
  logic [TexelW-1:0]   texel_row_o;
  logic [ColorW-1:0]   fill_color_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ColorW-1:0]   cfg_data_i = '0;
  int                  fail_count;
  int                  pending;
  bit                  quiet = 1'b0;
  int                  cur_height = 480;

  raycast_wall_column_texel_top dut (.*);

  rcwt_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .hit_x_i, .hit_y_i,
    .ray_length_i, .angle_offset_i, .row_i, .out_valid_i(out_valid_o), .out_stall_i,
    .region_i(region_o), .face_i(face_o), .texel_col_i(texel_col_o),
    .texel_row_i(texel_row_o), .fill_color_i(fill_color_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Write one register and wait for the beat to be taken.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[ColorW-1:0];
    if (idx == CfgScreenHeight) cur_height = int'(val & 32'hFFF);
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned h, input int unsigned c, input int unsigned f,
                          input int unsigned tw, input int unsigned th);
    write_reg(CfgScreenHeight, h);
    write_reg(CfgCeilingColor, c);
    write_reg(CfgFloorColor, f);
    write_reg(CfgTextureWidth, tw);
    write_reg(CfgTextureHeight, th);
  endtask

  // Present one pixel-row beat, with an optional idle burst ahead of it.
  task automatic send_row(input logic [HitW-1:0] hx, input logic [HitW-1:0] hy,
                          input logic [LenW-1:0] len, input logic [AngW-1:0] ang,
                          input logic [RowW-1:0] row);
    bit stalled;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    hit_x_i <= hx;
    hit_y_i <= hy;
    ray_length_i <= len;
    angle_offset_i <= ang;
    row_i <= row;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Mostly plausible geometry, with fractions near cell edges and some raw noise.
  task automatic send_random_row();
    logic [HitW-1:0] hx, hy;
    logic [LenW-1:0] len;
    logic [AngW-1:0] ang;
    logic [RowW-1:0] row;
    int              lim;
    hx = HitW'($urandom);
    hy = HitW'($urandom);
    case ($urandom_range(0, 5))
      0: hx[15:0] = 16'($urandom_range(0, 1));
      1: hx[15:0] = 16'(32'hFFFF - $urandom_range(0, 1));
      2: hy[15:0] = 16'($urandom_range(0, 1));
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: len = LenW'($urandom);
      1: len = LenW'($urandom_range(0, 3));
      default: len = LenW'($urandom_range(1 << 13, 1 << 20));
    endcase
    if ($urandom_range(0, 9) == 0) ang = AngW'($urandom);
    else ang = 16'($signed($urandom_range(0, 51472)) - 25736);
    lim = (cur_height > 2047) ? 2047 : cur_height;
    if ($urandom_range(0, 7) == 0) row = RowW'($urandom);
    else row = RowW'($urandom_range(0, lim));
    send_row(hx, hy, len, ang, row);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Result-side stall bursts; a burst ends early once the quiet phase starts.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!quiet) begin
        n = $urandom_range(1, 14);
        out_stall_i <= 1'b1;
        while (n > 0 && !quiet) begin
          @(posedge clk_i);
          n--;
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_regs(480, 24'h203040, 24'h605040, 64, 64);

    // Directed: field extremes, each face, saturation and boundary rows.
    send_row(22'h010000, 22'h018000, 22'h010000, 16'sd0, 11'd240);
    send_row(22'h02FFFF, 22'h018000, 22'h010000, 16'sd0, 11'd240);
    send_row(22'h018000, 22'h030000, 22'h010000, 16'sd0, 11'd240);
    send_row(22'h018000, 22'h034567, 22'h010000, 16'sd0, 11'd240);
    send_row(22'h000000, 22'h000000, 22'h010000, 16'sd0, 11'd240);
    send_row(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 16'sd25736, 11'd0);
    send_row(22'h3FFFFF, 22'h000000, 22'h3FFFFF, -16'sd25736, 11'd2047);
    send_row(22'h012345, 22'h000000, 22'h000000, 16'sd0, 11'd0);
    send_row(22'h012345, 22'h023456, 22'h000000, 16'sd0, 11'd480);
    send_row(22'h012345, 22'h023456, 22'h000000, 16'sd0, 11'd481);
    send_row(22'h012345, 22'h023456, 22'h000001, 16'h8000, 11'd100);
    send_row(22'h012345, 22'h023456, 22'h000001, 16'h7FFF, 11'd479);
    send_row(22'h012345, 22'h023456, 22'h040000, 16'sd1000, 11'd0);
    send_row(22'h012345, 22'h023456, 22'h040000, 16'sd1000, 11'd180);
    send_row(22'h012345, 22'h023456, 22'h040000, 16'sd1000, 11'd300);
    send_row(22'h012345, 22'h023456, 22'h040000, 16'sd1000, 11'd2047);
    send_row(22'h01FFFF, 22'h020000, 22'h010000, -16'sd12000, 11'd239);
    send_row(22'h00FFFF, 22'h010000, 22'h008000, 16'sd5000, 11'd241);
    repeat (200) send_random_row();
    in_valid_i <= 1'b0;
    drain();

    set_regs(1, 24'hFFFFFF, 24'h000000, 1, 1);
    repeat (200) send_random_row();
    in_valid_i <= 1'b0;
    drain();

    set_regs(2048, 24'h000000, 24'hFFFFFF, 256, 256);
    repeat (200) send_random_row();
    in_valid_i <= 1'b0;
    drain();

    set_regs(0, 24'hA5A5A5, 24'h5A5A5A, 0, 0);
    repeat (150) send_random_row();
    in_valid_i <= 1'b0;
    drain();

    set_regs(4095, 24'h123456, 24'hFEDCBA, 511, 511);
    repeat (150) send_random_row();
    in_valid_i <= 1'b0;
    drain();

    set_regs($urandom_range(1, 2048), $urandom, $urandom, $urandom_range(1, 256),
             $urandom_range(1, 256));
    repeat (150) send_random_row();
    quiet = 1'b1;
    repeat (200) send_random_row();
    in_valid_i <= 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== raycast_wall_column_texel_top.f =====
hdl/rcwt_pkg.sv
hdl/rcwt_cos_lookup.sv
hdl/rcwt_height_div.sv
hdl/rcwt_shade.sv
hdl/raycast_wall_column_texel_top.sv
test/rcwt_checker.sv
test/tb_top.sv
